// ===== hw/rtl/pud_pkg.sv =====
// Shared types, codes and the hex digit lookup for the percent decoder.
package pud_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned DIGIT_W = 5;

   localparam logic [PHASE_W-1:0] PHASE_PLAIN = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_HIGH  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_LOW   = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_SPARE = 2'd3;

   localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;

   localparam logic [DIGIT_W-1:0] DIGIT_NUL   = 5'd16;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 5'd10;

   // Outcome of one decode step: result fields plus the next state.
   typedef struct packed {
      logic                 has_result;
      logic [BYTE_W-1:0]    out_byte;
      logic                 byte_present;
      logic                 out_last;
      logic [PHASE_W-1:0]   phase;
      logic [DIGIT_W-1:0]   high_digit;
   } step_type;

   // Uppercase hex digit value; NUL maps to 16, anything else to 0.
   function automatic logic [DIGIT_W-1:0] digit_value(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] diff;
      diff = '0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         diff = b - CHAR_ZERO;
         return diff[DIGIT_W-1:0];
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         diff = b - CHAR_UPPER_A;
         return diff[DIGIT_W-1:0] + DIGIT_TEN;
      end else if (b == CHAR_NUL) begin
         return DIGIT_NUL;
      end
      return '0;
   endfunction

endpackage

// ===== hw/rtl/pud_decode.sv =====
// Combinational decode step: current escape state and one byte in, result and next state out.
module pud_decode (
   input  logic [1:0]         phase_i,
   input  logic [4:0]         high_digit_i,
   input  logic [7:0]         byte_i,
   input  logic               last_i,
   output pud_pkg::step_type  step_o
);
   import pud_pkg::*;

   logic [DIGIT_W-1:0] digit;
   logic [BYTE_W-1:0]  joined;

   assign digit  = digit_value(byte_i);
   assign joined = {high_digit_i[3:0], 4'b0000} | {{(BYTE_W-DIGIT_W){1'b0}}, digit};

   always_comb begin
      step_o              = '0;
      step_o.phase        = PHASE_PLAIN;
      step_o.high_digit   = high_digit_i;
      unique case (phase_i)
         PHASE_HIGH: begin
            step_o.high_digit = digit;
            if (last_i) begin
               // drop the partial escape, still close the string
               step_o.has_result = 1'b1;
               step_o.out_last   = 1'b1;
            end else begin
               step_o.phase = PHASE_LOW;
            end
         end
         PHASE_LOW: begin
            step_o.has_result   = 1'b1;
            step_o.out_byte     = joined;
            step_o.byte_present = 1'b1;
            step_o.out_last     = last_i;
         end
         PHASE_PLAIN, PHASE_SPARE: begin
            if (byte_i == CHAR_PERCENT) begin
               if (last_i) begin
                  step_o.has_result = 1'b1;
                  step_o.out_last   = 1'b1;
               end else begin
                  step_o.phase = PHASE_HIGH;
               end
            end else begin
               step_o.has_result   = 1'b1;
               step_o.out_byte     = (byte_i == CHAR_PLUS) ? CHAR_SPACE : byte_i;
               step_o.byte_present = 1'b1;
               step_o.out_last     = last_i;
            end
         end
         default: begin
            step_o = '0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/url_percent_decoder_core.sv =====
// Top level of the URL percent decoder: input register, decode step and result register.
//
// Usage:
//   req channel: one encoded byte per transfer (req_in_byte) with req_in_last on the
//   final byte of a string. rsp channel: zero or one decoded result per input byte;
//   rsp_byte_present says whether rsp_out_byte carries data, rsp_out_last closes the
//   string. A '%' and the first hex digit after it give no result unless last.
//   A taken transfer lands in the input register; its result, if any, is registered as the
//   byte leaves that register and is shown from then on. Throughput: one byte per cycle
//   unless a stalled result holds it, set by the single decode step between the registers.
//   The escape state (phase, high digit) advances when a byte leaves the input
//   register. While rsp_stall holds a waiting result, the input register still takes
//   one more byte; a byte that makes no result moves on regardless. req_stall rises
//   only when both registers are occupied and the held byte needs the output.
//   Reset (synchronous, active high) empties both registers and returns the decoder
//   to plain-byte phase.
module url_percent_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_present,
   output logic       rsp_out_last
);
   import pud_pkg::*;

   logic                 s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]    s1_byte_ff;
   logic                 s1_last_ff;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [DIGIT_W-1:0]   high_digit_ff, high_digit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_byte_ff;
   logic                 rsp_present_ff;
   logic                 rsp_last_ff;
   step_type             step;
   logic                 out_free;
   logic                 s1_advance;
   logic                 req_take;

   pud_decode u_decode (
      .phase_i      (phase_ff),
      .high_digit_i (high_digit_ff),
      .byte_i       (s1_byte_ff),
      .last_i       (s1_last_ff),
      .step_o       (step)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // a byte with no result never waits for the output
   assign s1_advance = s1_valid_ff && (!step.has_result || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_take   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in   = req_take || (s1_valid_ff && !s1_advance);
      phase_in      = s1_advance ? step.phase      : phase_ff;
      high_digit_in = s1_advance ? step.high_digit : high_digit_ff;
      rsp_valid_in  = (s1_advance && step.has_result) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PHASE_PLAIN;
         high_digit_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         high_digit_ff <= high_digit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_in_byte;
         s1_last_ff <= req_in_last;
      end
      if (s1_advance && step.has_result) begin
         rsp_byte_ff    <= step.out_byte;
         rsp_present_ff <= step.byte_present;
         rsp_last_ff    <= step.out_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_byte_present = rsp_present_ff;
   assign rsp_out_last     = rsp_last_ff;

`ifndef SYNTHESIS
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PHASE_SPARE)
      else $error("decoder phase reached unused code");

   a_stall_needs_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && step.has_result) |=> rsp_valid_ff)
      else $error("decoded result lost");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_present_ff) |-> rsp_last_ff)
      else $error("result without byte not marked last");

   a_last_resets_phase: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> (phase_ff == PHASE_PLAIN))
      else $error("phase not plain after end of string");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the URL percent decoder core.
`timescale 1ns / 1ps

module tb;
   import pud_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] value;
      logic       present;
      logic       last;
   } decoded_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_present;
   logic       rsp_out_last;

   logic [PHASE_W-1:0] dec_phase;
   logic [DIGIT_W-1:0] dec_high;
   decoded_type        expected_chars[$];
   logic [7:0]         enc_chars[$];
   decoded_type        want;
   decoded_type        got;
   int                 mismatches;
   int                 sent_items;
   int                 cycles;
   int                 rsp_hold;
   bit                 rush;

   url_percent_decoder_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_present (rsp_byte_present),
      .rsp_out_last     (rsp_out_last)
   );

   always #1 clock = ~clock;

   function automatic logic [DIGIT_W-1:0] hex_weight(input logic [7:0] b);
      logic [7:0] w;
      w = 8'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) w = b - CHAR_ZERO;
      else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) w = b - CHAR_UPPER_A + 8'd10;
      else if (b == CHAR_NUL) w = 8'd16;
      return w[DIGIT_W-1:0];
   endfunction

   // Advance the decoder state by one input byte and queue any result it yields.
   function automatic void decode_byte(input logic [7:0] b, input logic last);
      logic [8:0] joined;
      case (dec_phase)
         PHASE_HIGH: begin
            dec_high = hex_weight(b);
            if (last) begin
               dec_phase = PHASE_PLAIN;
               expected_chars.push_back('{8'd0, 1'b0, 1'b1});
            end else begin
               dec_phase = PHASE_LOW;
            end
         end
         PHASE_LOW: begin
            joined = {dec_high, 4'd0} | {4'd0, hex_weight(b)};
            dec_phase = PHASE_PLAIN;
            expected_chars.push_back('{joined[7:0], 1'b1, last});
         end
         default: begin
            dec_phase = PHASE_PLAIN;
            if (b == CHAR_PERCENT) begin
               if (last) expected_chars.push_back('{8'd0, 1'b0, 1'b1});
               else dec_phase = PHASE_HIGH;
            end else if (b == CHAR_PLUS) begin
               expected_chars.push_back('{CHAR_SPACE, 1'b1, last});
            end else begin
               expected_chars.push_back('{b, 1'b1, last});
            end
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_digit();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return CHAR_ZERO + 8'(r);
      if (r < 16) return CHAR_UPPER_A + 8'(r - 10);
      if (r == 16) return CHAR_NUL;
      if (r == 17) return 8'h61 + 8'($urandom_range(0, 5));
      return 8'($urandom_range(0, 255));
   endfunction

   // Present one byte and hold it until the transfer happens.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = rush ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_stall);
      decode_byte(b, last);
      sent_items++;
   endtask

   task automatic send_string();
      for (int i = 0; i < enc_chars.size(); i++)
         send_byte(enc_chars[i], i == enc_chars.size() - 1);
   endtask

   task automatic push_escape(input logic [7:0] hi, input logic [7:0] lo);
      enc_chars.push_back(CHAR_PERCENT);
      enc_chars.push_back(hi);
      enc_chars.push_back(lo);
   endtask

   // Hold the request side idle until every queued result has been seen.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chars.size() > 0) @(posedge clock);
   endtask

   task automatic build_string();
      int len;
      int kind;
      enc_chars.delete();
      len = $urandom_range(1, 10);
      repeat (len) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) push_escape(pick_digit(), pick_digit());
         else if (kind < 6) enc_chars.push_back(CHAR_PLUS);
         else enc_chars.push_back(8'($urandom_range(0, 255)));
      end
      // cut some strings short inside an escape
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         enc_chars.push_back(CHAR_PERCENT);
      end else if (kind == 1) begin
         enc_chars.push_back(CHAR_PERCENT);
         enc_chars.push_back(pick_digit());
      end
   endtask

   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_UPPER_A, 1'b0);
      send_byte(CHAR_PLUS, 1'b0);
      send_byte(CHAR_SPACE, 1'b0);
      send_byte(8'h7A, 1'b1);
   endtask

   task automatic test_escapes();
      enc_chars.delete();
      push_escape(CHAR_NINE, CHAR_UPPER_A);
      push_escape(CHAR_UPPER_F, CHAR_ZERO);
      push_escape(CHAR_NUL, CHAR_NUL);
      push_escape(8'h61, 8'h7E);
      push_escape(8'h32, 8'h42);
      send_string();
   endtask

   task automatic test_truncated_escapes();
      send_byte(CHAR_PERCENT, 1'b1);
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte(CHAR_UPPER_F, 1'b1);
   endtask

   task automatic test_random_strings(input int target);
      int next_pause;
      next_pause = sent_items + 300;
      while (sent_items < target) begin
         rush = ($urandom_range(0, 5) == 0);
         build_string();
         send_string();
         if (sent_items >= next_pause) begin
            wait_drained();
            next_pause += 300;
         end
      end
      rush = 1'b0;
   endtask

   task automatic test_random_noise(input int count);
      logic [7:0] b;
      repeat (count) begin
         b = ($urandom_range(0, 4) == 0) ? CHAR_PERCENT : 8'($urandom_range(0, 255));
         send_byte(b, $urandom_range(0, 5) == 0);
      end
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Receiver: stall for the count drawn at the previous result.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold <= rush ? 0 : $urandom_range(0, 10);
         got = '{rsp_out_byte, rsp_byte_present, rsp_out_last};
         if (expected_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: byte %02h present %0b last %0b",
                        got.value, got.present, got.last);
         end else begin
            want = expected_chars.pop_front();
            if (want != got) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"mismatch: want byte %02h present %0b last %0b, ",
                            "got byte %02h present %0b last %0b"},
                           want.value, want.present, want.last,
                           got.value, got.present, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'd0;
      req_in_last = 1'b0;
      rsp_stall   = 1'b0;
      rsp_hold    = 0;
      rush        = 1'b0;
      mismatches  = 0;
      sent_items  = 0;
      cycles      = 0;
      dec_phase   = PHASE_PLAIN;
      dec_high    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_plain_bytes();
      test_escapes();
      test_truncated_escapes();
      test_random_strings(1250);
      test_random_noise(150);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
